// ===== hdl/deq_pkg.sv =====
// Shared constants for the double-ended queue: widths, opcodes, status codes.
`timescale 1ns / 1ps

package deq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int OPCODE_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_LIST_FWD   = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_LIST_REV   = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== hdl/double_ended_queue_unit.sv =====
// Top level of the double-ended queue: ring buffer control around the entry store.
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a ring buffer of
// QUEUE_DEPTH entries (2..64), addressed by a front index and an entry count.
// A transaction is taken on a rising edge with start high and busy low. Push,
// pop and peek give a single result on o_valid in the cycle right after the
// transaction, and busy stays low, so a new transaction may follow every
// cycle. A listing of N stored entries gives N results on consecutive cycles
// starting the cycle after the transaction; busy is high while the entries
// after the first are read, since the one read port of the entry store
// fetches one entry per cycle. Results are shown for exactly one cycle and
// cannot be stalled; a downstream consumer must take every o_valid cycle.
// Pushing onto a full queue drops the value (status full); popping, peeking
// or listing an empty queue gives one empty result.
// The entry store needs no clearing after reset: only written entries are read.

module double_ended_queue_unit #(
    parameter int QUEUE_DEPTH = deq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [deq_pkg::OPCODE_W-1:0]           i_opcode,
    input  logic signed [deq_pkg::VALUE_W-1:0]     i_item_value,
    output logic                                   o_valid,
    output logic signed [deq_pkg::VALUE_W-1:0]     o_result_value,
    output logic [deq_pkg::STATUS_W-1:0]           o_status,
    output logic                                   o_last_of_run,
    output logic [deq_pkg::COUNT_OUT_W-1:0]        o_entry_count
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;

    // controller states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    // slot k places after base, with one wrap
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] k);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(k);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            wrap_add = IDX_W'(s - SUM_W'(QUEUE_DEPTH));
        end else begin
            wrap_add = IDX_W'(s);
        end
    endfunction

    // slot just before s, wrapping at zero
    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] s);
        if (s == '0) begin
            wrap_dec = IDX_W'(QUEUE_DEPTH - 1);
        end else begin
            wrap_dec = s - IDX_W'(1);
        end
    endfunction

    // queue state
    logic             r_state,  n_state;
    logic [IDX_W-1:0] r_front,  n_front;
    logic [CNT_W-1:0] r_count,  n_count;
    // listing walk
    logic [IDX_W-1:0] r_cursor, n_cursor;
    logic [CNT_W-1:0] r_left,   n_left;
    logic             r_fwd,    n_fwd;

    // result register; r_out_mem selects the store's read data as the value
    logic                                r_out_valid,  n_out_valid;
    logic                                r_out_mem,    n_out_mem;
    logic signed [deq_pkg::VALUE_W-1:0]  r_out_value,  n_out_value;
    logic [deq_pkg::STATUS_W-1:0]        r_out_status, n_out_status;
    logic                                r_out_last,   n_out_last;
    logic [CNT_W-1:0]                    r_out_count,  n_out_count;

    // entry store ports
    logic                               ram_we;
    logic [IDX_W-1:0]                   ram_waddr;
    logic                               ram_re;
    logic [IDX_W-1:0]                   ram_raddr;
    logic signed [deq_pkg::VALUE_W-1:0] ram_rdata;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [IDX_W-1:0] back_slot;
    logic [IDX_W-1:0] push_back_slot;
    logic [IDX_W-1:0] push_front_slot;
    logic [IDX_W-1:0] list_next;

    assign busy     = (r_state == S_LIST);
    assign accept   = start && !busy;
    assign is_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);

    // back slot is only used when the queue holds entries
    assign back_slot       = wrap_add(r_front, r_count - CNT_W'(1));
    assign push_back_slot  = wrap_add(r_front, r_count);
    assign push_front_slot = wrap_dec(r_front);
    assign list_next       = r_fwd ? wrap_add(r_cursor, CNT_W'(1)) : wrap_dec(r_cursor);

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_left       = r_left;
        n_fwd        = r_fwd;
        n_out_valid  = 1'b0;
        n_out_mem    = r_out_mem;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = push_back_slot;
        ram_re       = 1'b0;
        ram_raddr    = r_front;

        if (r_state == S_LIST) begin
            // one entry per cycle; r_left counts entries not yet read
            ram_re       = 1'b1;
            ram_raddr    = list_next;
            n_cursor     = list_next;
            n_left       = r_left - CNT_W'(1);
            n_out_valid  = 1'b1;
            n_out_mem    = 1'b1;
            n_out_status = deq_pkg::ST_OK;
            n_out_last   = (r_left == CNT_W'(1));
            n_out_count  = r_count;
            if (r_left == CNT_W'(1)) begin
                n_state = S_IDLE;
            end
        end else if (accept) begin
            n_out_valid = 1'b1;
            n_out_mem   = 1'b0;
            n_out_value = '0;
            n_out_last  = 1'b1;
            case (i_opcode)
                deq_pkg::OP_PUSH_FRONT,
                deq_pkg::OP_PUSH_BACK: begin
                    if (is_full) begin
                        n_out_status = deq_pkg::ST_FULL;
                        n_out_count  = r_count;
                    end else begin
                        ram_we       = 1'b1;
                        n_count      = r_count + CNT_W'(1);
                        n_out_value  = i_item_value;
                        n_out_status = deq_pkg::ST_OK;
                        n_out_count  = r_count + CNT_W'(1);
                        if (i_opcode == deq_pkg::OP_PUSH_FRONT) begin
                            ram_waddr = push_front_slot;
                            n_front   = push_front_slot;
                        end else begin
                            ram_waddr = push_back_slot;
                        end
                    end
                end
                deq_pkg::OP_POP_FRONT,
                deq_pkg::OP_POP_BACK,
                deq_pkg::OP_PEEK_FRONT,
                deq_pkg::OP_PEEK_BACK: begin
                    if (is_empty) begin
                        n_out_status = deq_pkg::ST_EMPTY;
                        n_out_count  = r_count;
                    end else begin
                        ram_re       = 1'b1;
                        n_out_mem    = 1'b1;
                        n_out_status = deq_pkg::ST_OK;
                        n_out_count  = r_count;
                        if (i_opcode == deq_pkg::OP_POP_FRONT ||
                            i_opcode == deq_pkg::OP_PEEK_FRONT) begin
                            ram_raddr = r_front;
                        end else begin
                            ram_raddr = back_slot;
                        end
                        if (i_opcode == deq_pkg::OP_POP_FRONT) begin
                            n_front     = wrap_add(r_front, CNT_W'(1));
                            n_count     = r_count - CNT_W'(1);
                            n_out_count = r_count - CNT_W'(1);
                        end else if (i_opcode == deq_pkg::OP_POP_BACK) begin
                            n_count     = r_count - CNT_W'(1);
                            n_out_count = r_count - CNT_W'(1);
                        end
                    end
                end
                deq_pkg::OP_LIST_FWD,
                deq_pkg::OP_LIST_REV: begin
                    if (is_empty) begin
                        n_out_status = deq_pkg::ST_EMPTY;
                        n_out_count  = r_count;
                    end else begin
                        // first entry is read now; the rest walk in S_LIST
                        n_fwd        = (i_opcode == deq_pkg::OP_LIST_FWD);
                        ram_re       = 1'b1;
                        ram_raddr    = (i_opcode == deq_pkg::OP_LIST_FWD) ? r_front : back_slot;
                        n_cursor     = ram_raddr;
                        n_left       = r_count - CNT_W'(1);
                        n_out_mem    = 1'b1;
                        n_out_status = deq_pkg::ST_OK;
                        n_out_last   = (r_count == CNT_W'(1));
                        n_out_count  = r_count;
                        if (r_count != CNT_W'(1)) begin
                            n_state = S_LIST;
                        end
                    end
                end
                default: begin
                    n_out_status = deq_pkg::ST_EMPTY;
                    n_out_count  = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_left      <= '0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_left      <= n_left;
            r_fwd       <= n_fwd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_mem    <= n_out_mem;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_count  <= n_out_count;
    end

    deq_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (i_item_value),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_mem ? ram_rdata : r_out_value;
    assign o_status       = r_out_status;
    assign o_last_of_run  = r_out_last;
    assign o_entry_count  = deq_pkg::COUNT_OUT_W'(r_out_count);

    // count stays within the ring
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // every transaction gets a result on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("transaction without result");

    // a listing run has no gaps
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_run) |=> o_valid)
        else $error("listing run broken");

    // no push lands in the store while a listing walks it
    a_no_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !ram_we)
        else $error("store written during listing");

    // a dropped push only when the ring is full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == deq_pkg::ST_FULL)
            |-> (o_entry_count == deq_pkg::COUNT_OUT_W'(QUEUE_DEPTH)))
        else $error("full status with room left");

endmodule

// ===== hdl/deq_ram.sv =====
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int QUEUE_DEPTH = deq_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W       = 6
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [IDX_W-1:0]                  i_wr_addr,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [IDX_W-1:0]                  i_rd_addr,
    output logic signed [deq_pkg::VALUE_W-1:0] o_rd_data
);

    logic signed [deq_pkg::VALUE_W-1:0] r_mem [QUEUE_DEPTH];
    logic signed [deq_pkg::VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
